[sv/assert_macros.svh]
// Assertion macros shared by the octave value noise RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that a property holds at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed: %m");

// Check that a condition never holds at a rising clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen: %m");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[sv/ovn2d_pkg.sv]
// Package for the 2D octave value noise block: field widths, codes, defaults.
// No dependencies; used by the interfaces, the top level and the testbench.
package ovn2d_pkg;

	// Default map size (log2 of the side) and seed fraction width
	localparam int LOG2_SIZE_DEF = 7;
	localparam int SEED_BITS_DEF = 16;

	// Fixed widths of the transaction fields
	localparam int ACT_W = 1;
	localparam int POS_W = 7;
	localparam int VAL_W = 16;
	localparam int OCT_W = 3;

	// Widest weight total numerator, 2^K - 1 with K held in OCT_W bits
	localparam int DEN_W = OCT_W + 4;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_WRITE = 1'b0;
	localparam logic [ACT_W-1:0] ACT_QUERY = 1'b1;

	// Octave count after reset
	localparam logic [OCT_W-1:0] OCT_RESET = 3'd7;

endpackage

[sv/ovn2d_ifs.sv]
// Valid/ready channel interfaces for the octave value noise block.
// Depends on ovn2d_pkg for the field widths.
interface ovn2d_item_if;
	logic                          valid;
	logic                          ready;
	logic [ovn2d_pkg::ACT_W-1:0]   action;
	logic [ovn2d_pkg::POS_W-1:0]   pos_x;
	logic [ovn2d_pkg::POS_W-1:0]   pos_y;
	logic [ovn2d_pkg::VAL_W-1:0]   seed_value;

	modport source (output valid, output action, output pos_x, output pos_y,
		output seed_value, input ready);
	modport sink (input valid, input action, input pos_x, input pos_y,
		input seed_value, output ready);
endinterface

interface ovn2d_result_if;
	logic                          valid;
	logic                          ready;
	logic [ovn2d_pkg::VAL_W-1:0]   noise_value;

	modport source (output valid, output noise_value, input ready);
	modport sink (input valid, input noise_value, output ready);
endinterface

[sv/octave_value_noise_2d_unit.sv]
// Top level of the 2D octave value noise block: sequencer, blend datapath, divider.
// Depends on ovn2d_pkg, ovn2d_ifs, ovn2d_seed_ram and assert_macros.svh.
//
// Usage:
//   item   : valid/ready input. action ACT_WRITE stores seed_value at
//            (pos_x, pos_y); ACT_QUERY returns the noise at (pos_x, pos_y).
//   result : valid/ready output carrying noise_value, one per query.
//   cfg_we / cfg_wdata : octave count K, written while the block is idle.
// A write transaction yields no result. A query reads
// the four cell corners of each octave through the single read port of the
// seed RAM, one per cycle, then divides the weighted sum by the weight total
// one quotient bit per cycle. The next item is taken only once the result
// has been loaded into the output register and the block is idle again.
// The result sits in an output register; a stalled receiver holds it there
// while the block accepts further items, and a later query waits only when
// its own result finds that register still full.
// Reset clears control state and sets K to 7; the seed map is not cleared
// and must be written before it is read.
`include "assert_macros.svh"

module octave_value_noise_2d_unit #(
	parameter int LOG2_SIZE = ovn2d_pkg::LOG2_SIZE_DEF,
	parameter int SEED_BITS = ovn2d_pkg::SEED_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ovn2d_item_if.sink                  item,
	ovn2d_result_if.source              result,
	input  logic                        cfg_we,
	input  logic [ovn2d_pkg::OCT_W-1:0] cfg_wdata
);

	localparam int L     = LOG2_SIZE;
	localparam int AW    = 2 * L;
	localparam int PW    = L + 1;
	localparam int WW    = 2 * L + 1;
	localparam int PRW   = WW + SEED_BITS;
	localparam int TW    = 3 * L + SEED_BITS;
	localparam int NW    = L + SEED_BITS;
	localparam int SHW   = $clog2(2 * L);
	localparam int DCW   = $clog2(SEED_BITS);
	localparam int OW    = ovn2d_pkg::OCT_W;
	localparam int DW    = ovn2d_pkg::DEN_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t             state_q, state_d;
	logic [OW-1:0]      oct_cfg_q;
	logic [OW-1:0]      k_eff;
	logic [OW-1:0]      k_q;
	logic [OW-1:0]      oct_q;
	logic [1:0]         corner_q;
	logic [L-1:0]       x_q, y_q;
	logic [L-1:0]       x_in, y_in;
	logic               item_fire;
	logic               query_fire;

	// Corner address and weight for the current issue slot
	logic [L-1:0]       pmask;
	logic [PW-1:0]      pitch;
	logic [L-1:0]       fx, fy, x1, y1, x2, y2, rx, ry;
	logic [PW-1:0]      wx, wy;
	logic [2*PW-1:0]    wprod;
	logic               issue;
	logic               last_issue;

	// Blend pipeline
	logic               v_s1, v_s2;
	logic [WW-1:0]      w_s1;
	logic [SHW-1:0]     sh_s1, sh_s2;
	logic [PRW-1:0]     p_s2;
	logic [SEED_BITS-1:0] rd_data;
	logic [TW-1:0]      acc_q;

	// Divider
	logic [DW:0]        den_full;
	logic [DW-1:0]      den_val;
	logic [NW-1:0]      rem_q, den_q;
	logic [SEED_BITS-1:0] quo_q;
	logic [DCW-1:0]     step_q;
	logic               div_load;
	logic               div_last;

	// Output register
	logic               res_valid_q;
	logic [ovn2d_pkg::VAL_W-1:0] res_data_q;
	logic               res_load;

	// Accept items only between queries
	assign item.ready = (state_q == ST_IDLE);
	assign item_fire  = item.valid && item.ready;
	assign query_fire = item_fire && (item.action == ovn2d_pkg::ACT_QUERY);
	assign x_in       = L'(item.pos_x);
	assign y_in       = L'(item.pos_y);

	// Clamp the octave count to one through LOG2_SIZE
	always_comb begin
		if (oct_cfg_q == '0) begin
			k_eff = OW'(1);
		end else if (oct_cfg_q > LOG2_SIZE) begin
			k_eff = OW'(LOG2_SIZE);
		end else begin
			k_eff = oct_cfg_q;
		end
	end

	// Derive the cell corners and bilinear weights of the current octave
	always_comb begin
		pmask = {L{1'b1}} >> oct_q;
		pitch = {1'b0, pmask} + PW'(1);
		fx    = x_q & pmask;
		fy    = y_q & pmask;
		x1    = x_q & ~pmask;
		y1    = y_q & ~pmask;
		x2    = x1 + pitch[L-1:0];
		y2    = y1 + pitch[L-1:0];
		rx    = corner_q[0] ? x2 : x1;
		ry    = corner_q[1] ? y2 : y1;
		wx    = corner_q[0] ? PW'(fx) : (pitch - PW'(fx));
		wy    = corner_q[1] ? PW'(fy) : (pitch - PW'(fy));
		wprod = wx * wy;
	end

	assign issue      = (state_q == ST_READ);
	assign last_issue = issue && (corner_q == 2'd3) && (oct_q == k_q - OW'(1));
	assign div_load   = (state_q == ST_DRAIN) && !v_s1 && !v_s2;
	assign div_last   = (state_q == ST_DIV) && (step_q == DCW'(SEED_BITS - 1));
	assign res_load   = (state_q == ST_DONE) && (!res_valid_q || result.ready);

	// Weight total numerator 2^K - 1
	assign den_full = ({{DW{1'b0}}, 1'b1} << k_q) - {{DW{1'b0}}, 1'b1};
	assign den_val  = den_full[DW-1:0];

	// Seed map
	ovn2d_seed_ram #(
		.ADDR_W (AW),
		.DATA_W (SEED_BITS)
	) u_seed_ram (
		.clk   (clk),
		.we    (item_fire && (item.action == ovn2d_pkg::ACT_WRITE)),
		.waddr ({y_in, x_in}),
		.wdata (SEED_BITS'(item.seed_value)),
		.re    (issue),
		.raddr ({ry, rx}),
		.rdata (rd_data)
	);

	// Sequence one query through read, drain, divide and hand-off
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (query_fire) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (div_load) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			oct_cfg_q   <= ovn2d_pkg::OCT_RESET;
			k_q         <= OW'(1);
			oct_q       <= '0;
			corner_q    <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				oct_cfg_q <= cfg_wdata;
			end
			// Latch the octave count and rewind the counters per query
			if (query_fire) begin
				k_q      <= k_eff;
				oct_q    <= '0;
				corner_q <= '0;
			end else if (issue) begin
				corner_q <= corner_q + 2'd1;
				if (corner_q == 2'd3) begin
					oct_q <= oct_q + OW'(1);
				end
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			// Count quotient bits
			if (div_load) begin
				step_q <= '0;
			end else if (state_q == ST_DIV) begin
				step_q <= step_q + DCW'(1);
			end
			// Hold the result until the receiver takes it
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: coordinates, blend pipeline, accumulator, divider, result
	always_ff @(posedge clk) begin
		if (query_fire) begin
			x_q   <= x_in;
			y_q   <= y_in;
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + (TW'(p_s2) << sh_s2);
		end
		w_s1  <= wprod[WW-1:0];
		sh_s1 <= SHW'(k_q) + SHW'(oct_q) - SHW'(1);
		p_s2  <= w_s1 * rd_data;
		sh_s2 <= sh_s1;
		// Restoring division, one quotient bit per cycle
		if (div_load) begin
			rem_q <= acc_q[TW-1:AW];
			den_q <= NW'(den_val) << (SEED_BITS - 1);
			quo_q <= '0;
		end else if (state_q == ST_DIV) begin
			if (rem_q >= den_q) begin
				rem_q <= rem_q - den_q;
				quo_q <= {quo_q[SEED_BITS-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[SEED_BITS-2:0], 1'b0};
			end
			den_q <= den_q >> 1;
		end
		if (res_load) begin
			res_data_q <= ovn2d_pkg::VAL_W'(quo_q);
		end
	end

	assign result.valid       = res_valid_q;
	assign result.noise_value = res_data_q;

	// The divider starts only after every blend term has reached the sum
	`ASSERT_CLK(a_drained_before_div, clk, arst_n, (state_q == ST_DIV) |-> (!v_s1 && !v_s2))
	// Seeds change only between queries
	`ASSERT_NEVER(a_write_in_query, clk, arst_n, item_fire && (state_q != ST_IDLE))
	// The octave counter stays below the latched count while reading
	`ASSERT_CLK(a_octave_bound, clk, arst_n, (state_q == ST_READ) |-> (oct_q < k_q))
	// A result is loaded only from a finished division
	`ASSERT_CLK(a_result_after_div, clk, arst_n, res_load |-> $past(state_q == ST_DIV || state_q == ST_DONE))

endmodule

[sv/ovn2d_seed_ram.sv]
// Seed map storage: one write port and one read port with registered read data.
// Contents are undefined until written; no reset. No package dependencies.
module ovn2d_seed_ram #(
	parameter int ADDR_W = 14,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// Write one seed, read one seed into the registered read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[dv/octave_value_noise_2d_unit_test.sv]
// Testbench for octave_value_noise_2d_unit: seed writes and noise queries, checked
// against an in-bench noise predictor. Needs ovn2d_pkg, ovn2d_ifs and the block RTL.
`timescale 1ns / 100ps

module octave_value_noise_2d_unit_test;

	localparam int LOG2_SIZE = ovn2d_pkg::LOG2_SIZE_DEF;
	localparam int SIDE = 1 << LOG2_SIZE;
	localparam int CELLS = SIDE * SIDE;
	// Settle wait, sized for the longest query (K = 7) plus some margin
	localparam int SETTLE_CYCLES = 4 * 7 + ovn2d_pkg::SEED_BITS_DEF + 4 + 16;
	localparam int PHASE_ITEMS = 190;
	localparam int HOLD_CYCLES = 400;
	localparam int NUM_PHASES = 10;

	typedef logic [ovn2d_pkg::POS_W-1:0] pos_t;
	typedef logic [ovn2d_pkg::VAL_W-1:0] frac_t;
	typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_QUERY} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		pos_t      x;
		pos_t      y;
		frac_t     val;
		logic      typed;
		frac_t     noise;
	} dir_row_t;

	// Directed rows: one octave first (only seed (0,0) counts), then a count of zero,
	// which acts as one, then two octaves, the second on the 64-pitch grid
	localparam int NUM_DIR = 19;
	localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
		'{ROW_CFG,   7'd0,   7'd0,   16'd1,      1'b0, 16'h0000},
		'{ROW_WRITE, 7'd0,   7'd0,   16'hFFFF,   1'b0, 16'h0000},
		'{ROW_QUERY, 7'd0,   7'd0,   16'h0000,   1'b1, 16'hFFFF},
		'{ROW_QUERY, 7'd127, 7'd127, 16'hFFFF,   1'b1, 16'hFFFF},
		'{ROW_WRITE, 7'd0,   7'd0,   16'h0000,   1'b0, 16'h0000},
		'{ROW_QUERY, 7'd127, 7'd0,   16'h5A5A,   1'b1, 16'h0000},
		'{ROW_CFG,   7'd0,   7'd0,   16'd0,      1'b0, 16'h0000},
		'{ROW_WRITE, 7'd0,   7'd0,   16'h8001,   1'b0, 16'h0000},
		'{ROW_QUERY, 7'd0,   7'd127, 16'hA5A5,   1'b1, 16'h8001},
		'{ROW_WRITE, 7'd127, 7'd127, 16'hFFFF,   1'b0, 16'h0000},
		'{ROW_QUERY, 7'd127, 7'd127, 16'h0000,   1'b1, 16'h8001},
		'{ROW_CFG,   7'd0,   7'd0,   16'd2,      1'b0, 16'h0000},
		'{ROW_WRITE, 7'd64,  7'd0,   16'h1234,   1'b0, 16'h0000},
		'{ROW_WRITE, 7'd0,   7'd64,  16'hFFFF,   1'b0, 16'h0000},
		'{ROW_WRITE, 7'd64,  7'd64,  16'h0000,   1'b0, 16'h0000},
		'{ROW_QUERY, 7'd0,   7'd0,   16'h0000,   1'b0, 16'h0000},
		'{ROW_QUERY, 7'd64,  7'd64,  16'h0000,   1'b0, 16'h0000},
		'{ROW_QUERY, 7'd127, 7'd127, 16'h0000,   1'b0, 16'h0000},
		'{ROW_QUERY, 7'd32,  7'd96,  16'h0000,   1'b0, 16'h0000}
	};

	// Octave settings of the random phases, extremes included
	localparam logic [ovn2d_pkg::OCT_W-1:0] PHASE_OCT [NUM_PHASES] =
		'{3'd7, 3'd3, 3'd1, 3'd5, 3'd0, 3'd7, 3'd6, 3'd2, 3'd4, 3'd7};

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [ovn2d_pkg::OCT_W-1:0]  cfg_wdata;

	ovn2d_item_if   item_ch ();
	ovn2d_result_if result_ch ();

	octave_value_noise_2d_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch.sink),
		.result    (result_ch.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow of the block state
	frac_t                       seed_map [CELLS];
	bit                          seed_set [CELLS];
	logic [ovn2d_pkg::OCT_W-1:0] oct_cfg;

	frac_t noise_due [$];

	bit   idle_en;
	bit   hold_req;
	int   hold_left;
	pos_t hot_base;
	pos_t last_x;
	pos_t last_y;
	int   item_count;
	int   write_count;
	int   query_count;
	int   result_count;
	int   fail_count;

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit
	initial begin
		#15_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Octave count in effect for a register value
	function automatic int eff_octaves(logic [ovn2d_pkg::OCT_W-1:0] k);
		int kk;
		kk = (k == '0) ? 1 : int'(k);
		if (kk > LOG2_SIZE)
			kk = LOG2_SIZE;
		return kk;
	endfunction

	// Lower or upper grid corner of a coordinate at octave o, wrapped
	function automatic pos_t grid_pt(pos_t c, int o, bit upper);
		int   sh;
		pos_t lo;
		sh = LOG2_SIZE - o;
		lo = pos_t'((int'(c) >> sh) << sh);
		return upper ? pos_t'(int'(lo) + (1 << sh)) : lo;
	endfunction

	// Exact noise: weighted bilinear sum over the octaves, truncated quotient
	function automatic frac_t noise_at(pos_t x, pos_t y, logic [ovn2d_pkg::OCT_W-1:0] k);
		int                kk;
		int                o;
		pos_t              x1, x2, y1, y2;
		longint unsigned   p, fx, fy, top, bot, total, divisor;
		kk = eff_octaves(k);
		total = 0;
		for (o = 0; o < kk; o++) begin
			x1 = grid_pt(x, o, 1'b0);
			x2 = grid_pt(x, o, 1'b1);
			y1 = grid_pt(y, o, 1'b0);
			y2 = grid_pt(y, o, 1'b1);
			p = longint'(1) << (LOG2_SIZE - o);
			fx = longint'(x) - longint'(x1);
			fy = longint'(y) - longint'(y1);
			top = (p - fx) * seed_map[{y1, x1}] + fx * seed_map[{y1, x2}];
			bot = (p - fx) * seed_map[{y2, x1}] + fx * seed_map[{y2, x2}];
			total += ((p - fy) * top + fy * bot) << (kk - 1 + o);
		end
		divisor = (longint'(1) << (2 * LOG2_SIZE)) * ((longint'(1) << kk) - 1);
		return frac_t'(total / divisor);
	endfunction

	// Seeds lean toward the extremes now and then
	function automatic frac_t pick_seed();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return frac_t'($urandom);
	endfunction

	// Mostly near the phase's hot spot so corners get reused
	function automatic pos_t pick_pos();
		if ($urandom_range(0, 9) < 6)
			return pos_t'(int'(hot_base) + $urandom_range(0, 15));
		return pos_t'($urandom_range(0, SIDE - 1));
	endfunction

	// Offer one transaction, hold it until accepted, then update the shadow
	task automatic send_item(logic [ovn2d_pkg::ACT_W-1:0] act, pos_t x, pos_t y,
		frac_t val, bit typed, frac_t typed_noise);
		@(negedge clk);
		while (idle_en && $urandom_range(0, 99) < 10) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.action     <= act;
		item_ch.pos_x      <= x;
		item_ch.pos_y      <= y;
		item_ch.seed_value <= val;
		do
			@(posedge clk);
		while (item_ch.ready !== 1'b1);
		item_count++;
		if (act == ovn2d_pkg::ACT_WRITE) begin
			seed_map[{y, x}] = val;
			seed_set[{y, x}] = 1'b1;
			write_count++;
		end else begin
			noise_due.push_back(typed ? typed_noise : noise_at(x, y, oct_cfg));
			query_count++;
		end
	endtask

	// Write every corner the query will read that holds no seed yet
	task automatic prime_corners(pos_t x, pos_t y);
		int   o;
		int   c;
		pos_t cx, cy;
		for (o = 0; o < eff_octaves(oct_cfg); o++) begin
			for (c = 0; c < 4; c++) begin
				cx = grid_pt(x, o, c[0]);
				cy = grid_pt(y, o, c[1]);
				if (!seed_set[{cy, cx}])
					send_item(ovn2d_pkg::ACT_WRITE, cx, cy, pick_seed(), 1'b0, '0);
			end
		end
	endtask

	// Drop valid, wait for all results, then let the block settle
	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (noise_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_octaves(logic [ovn2d_pkg::OCT_W-1:0] k);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= k;
		@(negedge clk);
		cfg_we    <= 1'b0;
		oct_cfg = k;
	endtask

	// Receiver: random stalls plus one long hold-off on request
	initial begin
		bit hold_done;
		result_ch.ready = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= !(idle_en && $urandom_range(0, 99) < 10);
			end
		end
	end

	// Compare each result transaction with the oldest expected noise
	always @(posedge clk) begin
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (noise_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got noise_value %h",
					$time, result_ch.noise_value);
				fail_count++;
			end else begin
				if (result_ch.noise_value !== noise_due[0]) begin
					$display("%0t: noise_value mismatch, expected %h, got %h",
						$time, noise_due[0], result_ch.noise_value);
					fail_count++;
				end
				void'(noise_due.pop_front());
				result_count++;
			end
		end
	end

	// Stimulus
	initial begin
		int       i;
		int       ph;
		int       phase_end;
		int       r;
		pos_t     qx, qy;
		dir_row_t row;

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		item_ch.valid      = 1'b0;
		item_ch.action     = ovn2d_pkg::ACT_WRITE;
		item_ch.pos_x      = '0;
		item_ch.pos_y      = '0;
		item_ch.seed_value = '0;
		oct_cfg            = ovn2d_pkg::OCT_RESET;
		idle_en            = 1'b1;
		hold_req           = 1'b0;
		hot_base           = '0;
		last_x             = '0;
		last_y             = '0;
		item_count         = 0;
		write_count        = 0;
		query_count        = 0;
		result_count       = 0;
		fail_count         = 0;
		for (i = 0; i < CELLS; i++)
			seed_set[i] = 1'b0;

		// Hold reset, then release it on a falling edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table
		for (i = 0; i < NUM_DIR; i++) begin
			row = DIR_ROWS[i];
			case (row.kind)
				ROW_CFG: begin
					drain();
					set_octaves(row.val[ovn2d_pkg::OCT_W-1:0]);
				end
				ROW_WRITE: send_item(ovn2d_pkg::ACT_WRITE, row.x, row.y, row.val, 1'b0, '0);
				default: send_item(ovn2d_pkg::ACT_QUERY, row.x, row.y, row.val,
					row.typed, row.noise);
			endcase
		end

		// Random phases, one octave setting each
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			set_octaves(PHASE_OCT[ph]);
			idle_en = (ph != 5);
			if (ph == 1)
				hold_req = 1'b1;
			case ($urandom_range(0, 2))
				0: hot_base = '0;
				1: hot_base = pos_t'(56);
				default: hot_base = pos_t'(120);
			endcase
			phase_end = item_count + PHASE_ITEMS;
			while (item_count < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					// Seed the cell corners, then query inside them
					qx = pick_pos();
					qy = pick_pos();
					prime_corners(qx, qy);
					send_item(ovn2d_pkg::ACT_QUERY, qx, qy, frac_t'($urandom), 1'b0, '0);
					last_x = qx;
					last_y = qy;
				end else if (r < 88) begin
					// Overwrite any cell
					send_item(ovn2d_pkg::ACT_WRITE, pos_t'($urandom), pos_t'($urandom),
						pick_seed(), 1'b0, '0);
				end else begin
					// Repeat the last query, seeding any of its corners that still lack a seed
					prime_corners(last_x, last_y);
					send_item(ovn2d_pkg::ACT_QUERY, last_x, last_y, frac_t'($urandom),
						1'b0, '0);
				end
			end
		end

		drain();
		$display("Covered %0d seed writes and %0d noise queries, %0d results checked,",
			write_count, query_count, result_count);
		$display("over octave counts 0 to 7 with random stalls and one long receiver hold-off.");
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
